// ----- rtl/core/mcpw_pkg.sv -----
package mcpw_pkg;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned OUT_BITS_W = 16;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned CH_W       = 4;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned FRAC_BITS  = 12;

  localparam logic [OP_W-1:0] OP_TICK = 2'd0;
  localparam logic [OP_W-1:0] OP_SET  = 2'd1;
  localparam logic [OP_W-1:0] OP_FEED = 2'd2;

  localparam int unsigned REG_MODE_MASK = 0;

  typedef struct packed {
    logic [OP_W-1:0]           opcode;
    logic [CH_W-1:0]           channel;
    logic signed [LEVEL_W-1:0] duty_value;
  } mcpw_item_t;

  typedef struct packed {
    logic                  cycle_start;
    logic                  watchdog_level;
    logic [OUT_BITS_W-1:0] output_bits;
  } mcpw_result_t;

endpackage

// ----- rtl/core/mcpw_duty_conv.sv -----
module mcpw_duty_conv
  import mcpw_pkg::*;
#(
  parameter int unsigned PERIOD_STEPS = 100,
  parameter int unsigned DUTY_W       = 7
) (
  input  logic                      pwm,
  input  logic signed [LEVEL_W-1:0] duty_value,
  output logic [DUTY_W-1:0]         duty
);

  localparam int unsigned MAG_W  = LEVEL_W - 1;
  localparam int unsigned PROD_W = MAG_W + DUTY_W;
  localparam int unsigned Q_W    = PROD_W - FRAC_BITS;

  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod;
  logic [Q_W-1:0]    quot;

  assign mag  = duty_value[MAG_W-1:0];
  assign prod = PROD_W'(mag) * PROD_W'(PERIOD_STEPS);
  assign quot = prod[PROD_W-1:FRAC_BITS];

  always_comb begin
    if (!pwm) begin
      duty = (duty_value != '0) ? DUTY_W'(PERIOD_STEPS) : '0;
    end else if (duty_value[LEVEL_W-1] || duty_value == '0) begin
      duty = '0;
    end else if (quot > Q_W'(PERIOD_STEPS)) begin
      duty = DUTY_W'(PERIOD_STEPS);
    end else begin
      duty = quot[DUTY_W-1:0];
    end
  end

endmodule

// ----- rtl/core/mcpw_core.sv -----
module mcpw_core
  import mcpw_pkg::*;
#(
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned PERIOD_STEPS = 100
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step_valid,
  input  mcpw_item_t            item,
  input  logic [OUT_BITS_W-1:0] mode_mask,
  output logic                  res_valid,
  output mcpw_result_t          res
);

  localparam int unsigned DUTY_W = $clog2(PERIOD_STEPS + 1);
  localparam int unsigned LANES  = (CHANNELS < OUT_BITS_W) ? CHANNELS : OUT_BITS_W;

  logic [DUTY_W-1:0] duty_store  [LANES];
  logic [DUTY_W-1:0] duty_shadow [LANES];
  logic [DUTY_W-1:0] phase_count;
  logic [DUTY_W-1:0] phase_cur;
  logic [DUTY_W-1:0] phase_next;
  logic              feed_pending;
  logic              is_tick;
  logic              is_set;
  logic              is_feed;
  logic              start;
  logic [DUTY_W-1:0] new_duty;
  logic [OUT_BITS_W-1:0] bits;

  assign is_tick = step_valid && (item.opcode == OP_TICK);
  assign is_set  = step_valid && (item.opcode == OP_SET);
  assign is_feed = step_valid && (item.opcode == OP_FEED);

  mcpw_duty_conv #(
    .PERIOD_STEPS(PERIOD_STEPS),
    .DUTY_W      (DUTY_W)
  ) u_conv (
    .pwm       (mode_mask[item.channel]),
    .duty_value(item.duty_value),
    .duty      (new_duty)
  );

  assign phase_cur  = (phase_count >= DUTY_W'(PERIOD_STEPS)) ? '0 : phase_count;
  assign start      = (phase_cur == '0);
  assign phase_next = (phase_cur == DUTY_W'(PERIOD_STEPS - 1)) ? '0 : phase_cur + 1'b1;

  always_comb begin
    bits = '0;
    for (int i = 0; i < LANES; i++) begin
      bits[i] = start ? (phase_cur < duty_store[i]) : (phase_cur < duty_shadow[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count  <= '0;
      feed_pending <= 1'b0;
      res_valid    <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        duty_store[i]  <= '0;
        duty_shadow[i] <= '0;
      end
    end else begin
      res_valid <= is_tick;
      if (is_feed) begin
        feed_pending <= 1'b1;
      end
      if (is_tick) begin
        feed_pending <= 1'b0;
        phase_count  <= phase_next;
        if (start) begin
          for (int i = 0; i < LANES; i++) begin
            duty_shadow[i] <= duty_store[i];
          end
        end
      end
      if (is_set) begin
        for (int i = 0; i < LANES; i++) begin
          if (item.channel == CH_W'(i)) begin
            duty_store[i] <= new_duty;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (is_tick) begin
      res.output_bits    <= bits;
      res.watchdog_level <= !feed_pending;
      res.cycle_start    <= start;
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_count < DUTY_W'(PERIOD_STEPS))
    else $error("phase out of range");

  a_tick_clears_feed: assert property (@(posedge clk) disable iff (rst)
    is_tick |=> !feed_pending && res_valid)
    else $error("tick left feed pending");

  a_feed_sets: assert property (@(posedge clk) disable iff (rst)
    is_feed |=> feed_pending)
    else $error("feed not recorded");

  a_phase_wrap: assert property (@(posedge clk) disable iff (rst)
    is_tick && phase_count == DUTY_W'(PERIOD_STEPS - 1) |=> phase_count == '0)
    else $error("phase did not wrap");

  a_start_latch: assert property (@(posedge clk) disable iff (rst)
    is_tick && start |=> res.cycle_start && $past(phase_count) == '0)
    else $error("cycle start mismatch");
`endif

endmodule

// ----- rtl/core/multichannel_pwm_with_watchdog_top.sv -----
// Sixteen-channel PWM generator with a watchdog level output.
// Input channel s_*: one item per handshake. s_tuser carries the opcode
// (tick, set duty, feed watchdog); s_tdata carries channel and a signed
// Q4.12 level. Set and feed items update state and give no output; every
// tick item gives exactly one output item on m_*, carrying the channel
// bits for the current phase, the watchdog level and a cycle-start flag.
// Configuration: APB register 0 (address 0) holds the per-channel mode
// mask, 1 for proportional PWM, 0 for on/off. Write it only while idle.
// Throughput: one item per cycle while no tick waits on a stalled output.
// An item is registered in the input register and then processed into
// the output register, from which a tick is presented on m_tvalid.
// Stall: a stalled m_tready holds the output item; set and feed items keep
// flowing until a tick reaches the input register, which then waits there
// until the output frees.
// Reset (synchronous, rst high): all duties, shadows, phase, feed flag and
// the mode mask clear; no output is pending.
module multichannel_pwm_with_watchdog_top
  import mcpw_pkg::*;
#(
  parameter int unsigned CHANNELS     = 16,
  parameter int unsigned PERIOD_STEPS = 100
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // channel[3:0], duty_value[19:4], zero pad
  input  logic [OP_W-1:0]       s_tuser,   // opcode[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // output_bits[15:0], watchdog_level[16],
                                           // cycle_start[17], zero pad
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  logic                  in_valid;
  mcpw_item_t            in_item;
  logic                  advance;
  logic [OUT_BITS_W-1:0] mode_mask;
  logic                  res_valid;
  mcpw_result_t          res;
  logic                  reg_hit;
  logic                  out_held;

  assign advance  = in_valid && (in_item.opcode != OP_TICK || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode     <= s_tuser;
      in_item.channel    <= s_tdata[CH_W-1:0];
      in_item.duty_value <= s_tdata[CH_W+LEVEL_W-1:CH_W];
    end
  end

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == 1'(REG_MODE_MASK));
  assign prdata  = reg_hit ? {16'b0, mode_mask} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_mask <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      mode_mask <= pwdata[OUT_BITS_W-1:0];
    end
  end

  mcpw_core #(
    .CHANNELS    (CHANNELS),
    .PERIOD_STEPS(PERIOD_STEPS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .step_valid(advance),
    .item      (in_item),
    .mode_mask (mode_mask),
    .res_valid (res_valid),
    .res       (res)
  );

  assign m_tvalid = res_valid || out_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_held <= 1'b0;
    end else begin
      out_held <= m_tvalid && !m_tready;
    end
  end

  assign m_tdata = {6'b0, res.cycle_start, res.watchdog_level, res.output_bits};

endmodule

// ----- tb/multichannel_pwm_with_watchdog_top_tb.sv -----
`timescale 1ns / 100ps

module multichannel_pwm_with_watchdog_top_tb;
  import mcpw_pkg::*;

  localparam int unsigned     PWM_STEPS     = 100;
  localparam int unsigned     PWM_CHANNELS  = 16;
  localparam logic [OP_W-1:0] OP_UNUSED     = 2'd3;
  localparam logic [2:0]      MODE_ADDR     = 3'(REG_MODE_MASK * 4);
  localparam logic [2:0]      SPARE_ADDR    = 3'(MODE_ADDR + 4);
  localparam int              HOLD_AT_FRAME = 60;
  localparam int              HOLD_CYCLES   = 400;
  localparam int              PHASE_ITEMS   = 215;

  typedef struct {
    bit           cfg;
    logic [2:0]   addr;
    logic [31:0]  wdata;
    mcpw_item_t   it;
    bit           typed;
    mcpw_result_t res;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [OP_W-1:0]       s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  logic [15:0]           mode_mask;
  logic [6:0]            duty_store  [PWM_CHANNELS];
  logic [6:0]            duty_shadow [PWM_CHANNELS];
  logic [6:0]            phase;
  bit                    feed_seen;

  mcpw_result_t          pending_pwm_frames [$];
  stim_row_t             rows [$];
  int                    mismatch_count;
  int                    frames_seen;
  int                    send_calm;
  int                    recv_calm;

  multichannel_pwm_with_watchdog_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [6:0] duty_from_level(input int unsigned ch,
                                                 input logic signed [15:0] lvl);
    int v;
    int q;
    v = lvl;
    if (!mode_mask[ch]) begin
      return (v != 0) ? 7'(PWM_STEPS) : 7'd0;
    end
    if (v <= 0) begin
      return 7'd0;
    end
    q = (v * PWM_STEPS) >> FRAC_BITS;
    if (q > PWM_STEPS) begin
      q = PWM_STEPS;
    end
    return 7'(q);
  endfunction

  task automatic predict_pwm_item(input mcpw_item_t it, output bit made,
                                  output mcpw_result_t r);
    bit start;
    made = 1'b0;
    r = '0;
    case (it.opcode)
      OP_SET: begin
        duty_store[it.channel] = duty_from_level(it.channel, it.duty_value);
      end
      OP_FEED: begin
        feed_seen = 1'b1;
      end
      OP_TICK: begin
        made = 1'b1;
        r.watchdog_level = !feed_seen;
        feed_seen = 1'b0;
        if (phase >= PWM_STEPS) begin
          phase = '0;
        end
        start = (phase == 0);
        r.cycle_start = start;
        for (int i = 0; i < PWM_CHANNELS; i++) begin
          if (start) begin
            duty_shadow[i] = duty_store[i];
          end
          r.output_bits[i] = (phase < duty_shadow[i]);
        end
        phase = phase + 7'd1;
        if (phase >= PWM_STEPS) begin
          phase = '0;
        end
      end
      default: begin
      end
    endcase
  endtask

  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 31) == 0) begin
      calm = $urandom_range(10, 40);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 8);
    end
  endtask

  task automatic offer_item(input mcpw_item_t it, input bit typed,
                            input mcpw_result_t res);
    int gap;
    bit made;
    mcpw_result_t r;
    draw_gap(send_calm, gap);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.opcode;
    s_tdata  <= {4'b0, it.duty_value, it.channel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_pwm_item(it, made, r);
    if (made) begin
      pending_pwm_frames.push_back(typed ? res : r);
    end
  endtask

  task automatic set_mode(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pwm_frames.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == MODE_ADDR) begin
      mode_mask = data[15:0];
    end
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= MODE_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0, mode_mask}) begin
      $error("pwm_mode_mask: expected %h, got %h", {16'h0, mode_mask}, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_item(input logic [1:0] op, input logic [3:0] ch,
                          input logic [15:0] lvl, input bit typed,
                          input logic [17:0] res);
    stim_row_t row;
    row.cfg   = 1'b0;
    row.addr  = '0;
    row.wdata = '0;
    row.it    = '{opcode: op, channel: ch, duty_value: lvl};
    row.typed = typed;
    row.res   = res;
    rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [2:0] addr, input logic [31:0] data);
    stim_row_t row;
    row       = '{default: '0};
    row.cfg   = 1'b1;
    row.addr  = addr;
    row.wdata = data;
    rows.push_back(row);
  endtask

  function automatic mcpw_item_t random_item();
    mcpw_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      it.opcode = OP_TICK;
    end else if (pick < 80) begin
      it.opcode = OP_SET;
    end else if (pick < 92) begin
      it.opcode = OP_FEED;
    end else begin
      it.opcode = OP_UNUSED;
    end
    it.channel = 4'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: it.duty_value = 16'($urandom_range(0, 4200));
      6:                it.duty_value = '0;
      7, 8:             it.duty_value = 16'($urandom);
      default:          it.duty_value = -16'sd1 * 16'($urandom_range(1, 4096));
    endcase
    return it;
  endfunction

  initial begin
    int gap;
    mcpw_result_t got;
    mcpw_result_t want;
    m_tready  = 1'b0;
    recv_calm = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (frames_seen == HOLD_AT_FRAME) begin
        gap = HOLD_CYCLES;
      end else begin
        draw_gap(recv_calm, gap);
      end
      @(negedge clk);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      got = mcpw_result_t'(m_tdata[17:0]);
      frames_seen++;
      if (pending_pwm_frames.size() == 0) begin
        $error("unexpected output item: %h", m_tdata);
        mismatch_count++;
      end else begin
        want = pending_pwm_frames.pop_front();
        if (got.output_bits !== want.output_bits) begin
          $error("output_bits: expected %h, got %h", want.output_bits, got.output_bits);
          mismatch_count++;
        end
        if (got.watchdog_level !== want.watchdog_level) begin
          $error("watchdog_level: expected %b, got %b",
                 want.watchdog_level, got.watchdog_level);
          mismatch_count++;
        end
        if (got.cycle_start !== want.cycle_start) begin
          $error("cycle_start: expected %b, got %b", want.cycle_start, got.cycle_start);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    logic [31:0] phase_masks [6];
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    mode_mask      = '0;
    phase          = '0;
    feed_seen      = 1'b0;
    mismatch_count = 0;
    frames_seen    = 0;
    send_calm      = 0;
    for (int i = 0; i < PWM_CHANNELS; i++) begin
      duty_store[i]  = '0;
      duty_shadow[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_item(OP_TICK,   4'd0,  16'h0000, 1'b1, {1'b1, 1'b1, 16'h0000});
    add_item(OP_FEED,   4'd0,  16'h0000, 1'b0, '0);
    add_item(OP_TICK,   4'd0,  16'h0000, 1'b1, {1'b0, 1'b0, 16'h0000});
    add_item(OP_SET,    4'd0,  16'h7FFF, 1'b0, '0);
    add_item(OP_SET,    4'd15, 16'h8000, 1'b0, '0);
    add_item(OP_SET,    4'd7,  16'h0000, 1'b0, '0);
    add_item(OP_SET,    4'd3,  16'h0001, 1'b0, '0);
    add_item(OP_UNUSED, 4'd5,  16'h04D2, 1'b0, '0);
    add_item(OP_FEED,   4'd0,  16'h0000, 1'b0, '0);
    add_item(OP_FEED,   4'd0,  16'h0000, 1'b0, '0);
    add_item(OP_TICK,   4'd0,  16'h0000, 1'b1, {1'b0, 1'b0, 16'h0000});
    add_item(OP_TICK,   4'd0,  16'h0000, 1'b1, {1'b0, 1'b1, 16'h0000});
    add_cfg(MODE_ADDR, 32'h0000_FFFF);
    add_item(OP_SET,    4'd0,  16'h1000, 1'b0, '0);
    add_item(OP_SET,    4'd1,  16'h7FFF, 1'b0, '0);
    add_item(OP_SET,    4'd2,  16'h0001, 1'b0, '0);
    add_item(OP_SET,    4'd3,  16'h0029, 1'b0, '0);
    add_item(OP_SET,    4'd4,  16'hFFFF, 1'b0, '0);
    add_item(OP_SET,    4'd5,  16'h8000, 1'b0, '0);
    add_item(OP_SET,    4'd6,  16'h0800, 1'b0, '0);
    add_item(OP_SET,    4'd7,  16'h0FFF, 1'b0, '0);
    add_item(OP_SET,    4'd8,  16'h0FD7, 1'b0, '0);
    add_item(OP_SET,    4'd9,  16'h1001, 1'b0, '0);
    add_item(OP_TICK,   4'd0,  16'h0000, 1'b0, '0);
    add_cfg(SPARE_ADDR, 32'h0000_0000);
    add_item(OP_SET,    4'd10, 16'h0800, 1'b0, '0);
    add_item(OP_TICK,   4'd0,  16'h0000, 1'b0, '0);

    foreach (rows[k]) begin
      if (rows[k].cfg) begin
        set_mode(rows[k].addr, rows[k].wdata);
      end else begin
        offer_item(rows[k].it, rows[k].typed, rows[k].res);
      end
    end

    phase_masks[0] = 32'($urandom_range(0, 16'hFFFF));
    phase_masks[1] = 32'hFFFF_FFFF;
    phase_masks[2] = 32'h0000_0000;
    phase_masks[3] = $urandom;
    phase_masks[4] = 32'h0000_5555;
    phase_masks[5] = 32'h0000_AAAA;
    foreach (phase_masks[p]) begin
      set_mode(MODE_ADDR, phase_masks[p]);
      repeat (PHASE_ITEMS) offer_item(random_item(), 1'b0, '0);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_pwm_frames.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
